// File: hw/rtl/bpdc_pkg.sv
// ----------------------------------------------------------------------------
// bpdc_pkg: shared definitions for the button press duration classifier
// Field widths, register map, phase codes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpdc_pkg;

  // Number of buttons watched; fixed by the width of the level word.
  localparam int unsigned ButtonCount = 3;
  localparam int unsigned BtnIdxW     = 2;
  localparam int unsigned TickW       = 16;

  // Configuration port
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned RegIdxW  = 2;

  localparam logic [RegIdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [RegIdxW-1:0] RegPoll      = 2'd1;
  localparam logic [RegIdxW-1:0] RegLongPress = 2'd2;

  localparam logic [TickW-1:0] DebounceReset  = 16'd100;
  localparam logic [TickW-1:0] PollReset      = 16'd10;
  localparam logic [TickW-1:0] LongPressReset = 16'd1000;

  // Press tracking phases
  localparam logic [1:0] PhIdle     = 2'd0;
  localparam logic [1:0] PhDebounce = 2'd1;
  localparam logic [1:0] PhHold     = 2'd2;
  localparam logic [1:0] PhRelease  = 2'd3;

  localparam logic PressShort = 1'b0;
  localparam logic PressLong  = 1'b1;

endpackage : bpdc_pkg

`default_nettype wire

// File: hw/rtl/bpdc_if.sv
// ----------------------------------------------------------------------------
// bpdc channels: valid/ready interfaces for level words and press reports
// A word moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpdc_lvl_if;
  logic                                 valid;
  logic                                 ready;
  logic [bpdc_pkg::ButtonCount-1:0]     button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface : bpdc_lvl_if

interface bpdc_press_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 press_kind;
  logic [bpdc_pkg::BtnIdxW-1:0]         button_index;

  modport source (output valid, output press_kind, output button_index, input ready);
  modport sink   (input valid, input press_kind, input button_index, output ready);
endinterface : bpdc_press_if

`default_nettype wire

// File: hw/rtl/button_press_duration_classifier_top.sv
// ----------------------------------------------------------------------------
// button_press_duration_classifier_top: short/long button press classifier
// Tracks one press at a time from millisecond level words and reports it.
// ----------------------------------------------------------------------------
// Each word on btn_i is one millisecond tick carrying the levels of three
// buttons. While no press is open, a rising edge starts one (highest button
// wins when several rise together); other edges are ignored until the report.
// After debounce_ticks the latched button is sampled; while it stays high it
// is resampled every poll_ticks, and the first low sample closes the press one
// poll period later. A press whose saturated tick count is at least
// long_press_ticks is reported long, otherwise short. The block takes one word
// per clock while press_o does not stall it: a word is captured into an input
// register, the press logic runs combinationally from it into the result
// register, which presents the report on press_o, and back-pressure on
// press_o only stalls btn_i once both registers are full. Write the registers
// only while no press is open.
// Register map (32-bit words): 0x0 debounce_ticks, 0x4 poll_ticks,
// 0x8 long_press_ticks, each in bits [15:0].
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module button_press_duration_classifier_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  bpdc_lvl_if.sink                               btn_i,
  bpdc_press_if.source                           press_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bpdc_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [bpdc_pkg::ApbDataW-1:0]     pwdata,
  output logic      [bpdc_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready
);

  localparam int unsigned TW = bpdc_pkg::TickW;
  localparam int unsigned BW = bpdc_pkg::BtnIdxW;
  localparam int unsigned NB = bpdc_pkg::ButtonCount;
  localparam logic [TW-1:0] TickMax = {TW{1'b1}};

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TW-1:0] debounce_q, poll_ticks_q, long_press_q;
  logic [bpdc_pkg::RegIdxW-1:0] reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bpdc_pkg::RegIdxW+1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bpdc_pkg::DebounceReset;
      poll_ticks_q <= bpdc_pkg::PollReset;
      long_press_q <= bpdc_pkg::LongPressReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bpdc_pkg::RegDebounce:  debounce_q   <= pwdata[TW-1:0];
        bpdc_pkg::RegPoll:      poll_ticks_q <= pwdata[TW-1:0];
        bpdc_pkg::RegLongPress: long_press_q <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bpdc_pkg::RegDebounce:  prdata[TW-1:0] = debounce_q;
      bpdc_pkg::RegPoll:      prdata[TW-1:0] = poll_ticks_q;
      bpdc_pkg::RegLongPress: prdata[TW-1:0] = long_press_q;
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register: hold one word until the press logic can take it
  // --------------------------------------------------------------------------
  logic          in_vld_q;
  logic [NB-1:0] lvl_q;
  logic          out_vld_q;
  logic          advance;

  assign advance     = in_vld_q && (!out_vld_q || press_o.ready);
  assign btn_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (btn_i.ready) begin
      in_vld_q <= btn_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (btn_i.valid && btn_i.ready) begin
      lvl_q <= btn_i.button_levels;
    end
  end

  // --------------------------------------------------------------------------
  // Press tracking
  // --------------------------------------------------------------------------
  logic [1:0]    phase_q, phase_d;
  logic [TW-1:0] elapsed_q, elapsed_d;
  logic [TW-1:0] poll_q, poll_d;
  logic [BW-1:0] active_q, active_d;
  logic [NB-1:0] prev_q;
  logic [NB-1:0] rising;
  logic [3:0]    lvl_ext;
  logic [TW-1:0] elapsed_inc, poll_inc;
  logic          level;
  logic          emit;
  logic          kind;

  assign rising      = lvl_q & ~prev_q;
  // Pad to four entries so an index that names no button reads low.
  assign lvl_ext     = {{(4-NB){1'b0}}, lvl_q};
  assign level       = lvl_ext[active_q];
  assign elapsed_inc = (elapsed_q == TickMax) ? TickMax : elapsed_q + TW'(1);
  assign poll_inc    = (poll_q == TickMax) ? TickMax : poll_q + TW'(1);
  assign kind        = (elapsed_inc < long_press_q) ? bpdc_pkg::PressShort
                                                    : bpdc_pkg::PressLong;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    poll_d    = poll_q;
    active_d  = active_q;
    emit      = 1'b0;
    unique case (phase_q)
      bpdc_pkg::PhIdle: begin
        if (rising != '0) begin
          // Later buttons override earlier ones: highest index wins.
          for (int i = 0; i < NB; i++) begin
            if (rising[i]) active_d = BW'(i);
          end
          elapsed_d = '0;
          poll_d    = '0;
          phase_d   = bpdc_pkg::PhDebounce;
        end
      end
      bpdc_pkg::PhDebounce: begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= debounce_q) begin
          if (!level) begin
            emit = 1'b1;
          end else begin
            phase_d = bpdc_pkg::PhHold;
            poll_d  = '0;
          end
        end
      end
      bpdc_pkg::PhHold: begin
        elapsed_d = elapsed_inc;
        poll_d    = poll_inc;
        if (poll_inc >= poll_ticks_q) begin
          poll_d = '0;
          if (!level) phase_d = bpdc_pkg::PhRelease;
        end
      end
      default: begin
        elapsed_d = elapsed_inc;
        poll_d    = poll_inc;
        if (poll_inc >= poll_ticks_q) emit = 1'b1;
      end
    endcase
    if (emit) begin
      phase_d = bpdc_pkg::PhIdle;
      poll_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bpdc_pkg::PhIdle;
      elapsed_q <= '0;
      poll_q    <= '0;
      active_q  <= '0;
      prev_q    <= '0;
    end else if (advance) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      poll_q    <= poll_d;
      active_q  <= active_d;
      prev_q    <= lvl_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: hold the report until the sink takes it
  // --------------------------------------------------------------------------
  logic          kind_q;
  logic [BW-1:0] idx_q;
  logic          out_vld_d;

  assign out_vld_d = (advance && emit) || (out_vld_q && !press_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q <= kind;
      idx_q  <= active_q;
    end
  end

  assign press_o.valid        = out_vld_q;
  assign press_o.press_kind   = kind_q;
  assign press_o.button_index = idx_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_emit_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |-> (phase_q != bpdc_pkg::PhIdle))
    else $error("report raised with no press open");

  a_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit) |=> (phase_q == bpdc_pkg::PhIdle))
    else $error("press still open after its report");

  a_idle_poll_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bpdc_pkg::PhIdle) |-> (poll_q == '0))
    else $error("poll counter not cleared while idle");

  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != bpdc_pkg::PhIdle) |-> (active_q < BW'(NB)))
    else $error("latched button index names no button");

  a_report_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !press_o.ready) |-> !advance)
    else $error("press logic advanced over a stalled report");

endmodule : button_press_duration_classifier_top

`default_nettype wire

// File: bench/tb_button_press_duration_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_button_press_duration_classifier_top: press classifier self-checking bench
// Feeds millisecond level words to the classifier. A cycle-free software twin
// of the press tracker predicts each short/long report, and the bench checks
// every report against it. Register settings change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_button_press_duration_classifier_top;

  localparam int unsigned NB = bpdc_pkg::ButtonCount;
  localparam int unsigned BW = bpdc_pkg::BtnIdxW;
  localparam int unsigned TW = bpdc_pkg::TickW;
  localparam int unsigned AW = bpdc_pkg::ApbAddrW;
  localparam int unsigned DW = bpdc_pkg::ApbDataW;
  localparam int unsigned IW = bpdc_pkg::RegIdxW;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReported = 10;

  typedef struct packed {
    logic          kind;
    logic [BW-1:0] idx;
  } press_report_t;

  logic clk_i;
  logic rst_ni;

  // APB-style register port
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  bpdc_lvl_if   btn_if ();
  bpdc_press_if rpt_if ();

  button_press_duration_classifier_top DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .btn_i   (btn_if),
    .press_o (rpt_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Press tracker twin: registers, phase and counters at the block's widths.
  logic [TW-1:0] reg_val [0:2];
  logic [1:0]    press_phase;
  logic [TW-1:0] ticks_since_edge;
  logic [TW-1:0] ticks_since_poll;
  logic [BW-1:0] latched_button;
  logic [NB-1:0] last_levels;

  // Reports predicted but not yet delivered, oldest first.
  press_report_t expected_reports [$];

  int unsigned mismatch_count;
  int unsigned words_sent;
  int unsigned reports_seen;
  int unsigned reg_writes;
  int unsigned cycle_count;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Give up if the run hangs: no correct run comes near this many cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TIMEOUT after %0d cycles, %0d reports pending", cycle_count,
               expected_reports.size());
      $display("button_press_duration_classifier_top test failed");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input int exp_v, input int act_v);
    mismatch_count++;
    if (mismatch_count <= MaxReported)
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $time);
  endtask

  // Advance the twin by one tick; return 1 and fill rep when the tick closes
  // a press. Saturating counters and >= compares keep every wait finite.
  function automatic logic classify_tick(input logic [NB-1:0] lv,
                                         output press_report_t rep);
    logic [NB-1:0] rose;
    logic          held;
    logic          closes;
    rose        = lv & ~last_levels;
    last_levels = lv;
    closes      = 1'b0;
    rep         = '0;
    if (press_phase == bpdc_pkg::PhIdle) begin
      if (rose != '0) begin
        // Highest rising button wins.
        for (int i = 0; i < NB; i++)
          if (rose[i]) latched_button = i[BW-1:0];
        ticks_since_edge = '0;
        ticks_since_poll = '0;
        press_phase      = bpdc_pkg::PhDebounce;
      end
      return 1'b0;
    end
    if (ticks_since_edge != '1) ticks_since_edge++;
    held = lv[latched_button];
    case (press_phase)
      bpdc_pkg::PhDebounce: begin
        if (ticks_since_edge >= reg_val[bpdc_pkg::RegDebounce]) begin
          if (!held) closes = 1'b1;
          else begin
            press_phase      = bpdc_pkg::PhHold;
            ticks_since_poll = '0;
          end
        end
      end
      bpdc_pkg::PhHold: begin
        if (ticks_since_poll != '1) ticks_since_poll++;
        if (ticks_since_poll >= reg_val[bpdc_pkg::RegPoll]) begin
          ticks_since_poll = '0;
          if (!held) press_phase = bpdc_pkg::PhRelease;
        end
      end
      default: begin
        if (ticks_since_poll != '1) ticks_since_poll++;
        if (ticks_since_poll >= reg_val[bpdc_pkg::RegPoll]) closes = 1'b1;
      end
    endcase
    if (closes) begin
      rep.kind         = (ticks_since_edge < reg_val[bpdc_pkg::RegLongPress])
                         ? bpdc_pkg::PressShort : bpdc_pkg::PressLong;
      rep.idx          = latched_button;
      press_phase      = bpdc_pkg::PhIdle;
      ticks_since_poll = '0;
    end
    return closes;
  endfunction

  // Report checker: compare each delivered report with the oldest prediction.
  always @(posedge clk_i) begin : report_check
    press_report_t want;
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        flag_mismatch("report with nothing pending", 0, 1);
      end else begin
        want = expected_reports.pop_front();
        if (rpt_if.press_kind !== want.kind)
          flag_mismatch("press_kind", want.kind, rpt_if.press_kind);
        if (rpt_if.button_index !== want.idx)
          flag_mismatch("button_index", want.idx, rpt_if.button_index);
      end
    end
  end

  // Report sink: alternate ready runs and stalls, with the odd long ready
  // stretch so that some phases see no back-pressure at all.
  initial begin : report_sink
    int  run_left;
    logic stalling;
    rpt_if.ready = 1'b0;
    run_left     = 0;
    stalling     = 1'b1;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        stalling = !stalling;
        if (stalling)
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
        else
          run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 300)
                                                 : $urandom_range(1, 10);
      end
      rpt_if.ready <= !stalling;
      run_left--;
    end
  end

  // Send one level word; entered and left at a falling edge. Insert a random
  // gap between bursts, hold the word until taken, then predict its tick.
  task automatic drive_levels(input logic [NB-1:0] lv);
    int unsigned   gap;
    press_report_t rep;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 48);
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
        btn_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    btn_if.valid         <= 1'b1;
    btn_if.button_levels <= lv;
    @(posedge clk_i);
    while (!btn_if.ready) @(posedge clk_i);
    words_sent++;
    burst_left--;
    if (classify_tick(lv, rep)) expected_reports.push_back(rep);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted report has arrived.
  task automatic drain_reports();
    btn_if.valid <= 1'b0;
    do @(negedge clk_i); while (expected_reports.size() != 0);
  endtask

  // Release everything until the open press, if any, has been reported.
  task automatic settle_press();
    while (press_phase != bpdc_pkg::PhIdle) drive_levels('0);
  endtask

  task automatic hold_press(input logic [NB-1:0] mask, input int unsigned ticks);
    repeat (ticks) drive_levels(mask);
    settle_press();
  endtask

  // Close the phase: no press open, no report due, block quiet.
  task automatic finish_phase();
    settle_press();
    drain_reports();
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready, then an idle
  // gap so back-to-back transfers never collide on the bus signals.
  task automatic apb_cycle(input logic wr, input logic [IW-1:0] idx,
                           input logic [DW-1:0] wdata, output logic [DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_reg(input logic [IW-1:0] idx);
    logic [DW-1:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    if (rd[TW-1:0] !== reg_val[idx])
      flag_mismatch("register readback", reg_val[idx], rd[TW-1:0]);
  endtask

  // Write a register with junk in the unused upper bits, then read it back.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [TW-1:0] val);
    logic [DW-1:0] wdata;
    logic [DW-1:0] unused;
    wdata         = $urandom();
    wdata[TW-1:0] = val;
    apb_cycle(1'b1, idx, wdata, unused);
    reg_val[idx] = val;
    reg_writes++;
    check_reg(idx);
  endtask

  task automatic set_regs(input logic [TW-1:0] debounce, input logic [TW-1:0] poll,
                          input logic [TW-1:0] long_press);
    write_reg(bpdc_pkg::RegDebounce, debounce);
    write_reg(bpdc_pkg::RegPoll, poll);
    write_reg(bpdc_pkg::RegLongPress, long_press);
  endtask

  // Reset values, and a button already held on the very first tick.
  task automatic test_reset_defaults();
    check_reg(bpdc_pkg::RegDebounce);
    check_reg(bpdc_pkg::RegPoll);
    check_reg(bpdc_pkg::RegLongPress);
    hold_press(3'b001, 150);
    hold_press(3'b100, 30);
    finish_phase();
  endtask

  // Tie-break, ignored edges, held-through-report, quick tap, long threshold.
  task automatic test_press_edges();
    set_regs(16'd4, 16'd3, 16'd12);
    hold_press(3'b111, 6);
    hold_press(3'b011, 6);
    // Latch button 0, then let the others rise: those edges must not count.
    drive_levels(3'b001);
    drive_levels(3'b011);
    drive_levels(3'b111);
    repeat (8) drive_levels(3'b101);
    // Drop button 0 but keep button 2 held through the report and after it.
    while (press_phase != bpdc_pkg::PhIdle) drive_levels(3'b100);
    repeat (4) drive_levels(3'b100);
    drive_levels(3'b000);
    // Tap released before the debounce sample: duration is the debounce time.
    hold_press(3'b010, 1);
    // Sweep hold length across the short/long boundary.
    for (int n = 1; n <= 14; n++) hold_press(3'b001, n);
    finish_phase();
  endtask

  // Smallest, zero and largest register values.
  task automatic test_register_extremes();
    set_regs(16'd1, 16'd1, 16'd1);
    hold_press(3'b001, 1);
    hold_press(3'b010, 3);
    hold_press(3'b100, 2);
    finish_phase();
    set_regs(16'd1, 16'd1, 16'd2);
    hold_press(3'b100, 1);
    hold_press(3'b010, 3);
    finish_phase();
    // Zero everywhere: each wait ends on the next tick and every press is long.
    set_regs(16'd0, 16'd0, 16'd0);
    hold_press(3'b010, 3);
    hold_press(3'b001, 1);
    finish_phase();
    // Largest values in every register, read back.
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Taps end at the debounce sample, clear of the longest poll period.
    set_regs(16'd1, 16'hFFFF, 16'hFFFF);
    hold_press(3'b001, 1);
    hold_press(3'b100, 1);
    finish_phase();
  endtask

  // Mostly clean presses with random content, plus noise and cut-off presses.
  task automatic test_random_traffic();
    int unsigned   start;
    int unsigned   hold;
    int unsigned   pick;
    logic [NB-1:0] mask;
    logic [NB-1:0] lv;
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(TW'($urandom_range(1, 16)), TW'($urandom_range(1, 8)),
               TW'($urandom_range(1, 64)));
      start = words_sent;
      while (words_sent - start < 200) begin
        // In one phase, hold the sender back until every pending report is out.
        if (ph == 2 && words_sent - start >= 100 && words_sent - start < 110) drain_reports();
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          mask = ($urandom_range(0, 3) == 0) ? NB'($urandom_range(1, 7))
                                             : NB'(3'b001 << $urandom_range(0, 2));
          drive_levels('0);
          hold = $urandom_range(1, reg_val[bpdc_pkg::RegDebounce]
                                   + 4 * reg_val[bpdc_pkg::RegPoll]
                                   + reg_val[bpdc_pkg::RegLongPress]);
          repeat (hold) begin
            lv = mask;
            if ($urandom_range(0, 4) == 0) lv = lv | NB'($urandom());
            drive_levels(lv);
          end
          settle_press();
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 6)) drive_levels(NB'($urandom()));
        end else begin
          drive_levels(NB'($urandom_range(1, 7)));
          repeat ($urandom_range(0, 4)) drive_levels(NB'($urandom()));
        end
      end
      finish_phase();
    end
  endtask

  initial begin
    // Known values on every input from time zero while reset is held.
    rst_ni               = 1'b0;
    btn_if.valid         = 1'b0;
    btn_if.button_levels = '0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    reg_val[bpdc_pkg::RegDebounce]  = bpdc_pkg::DebounceReset;
    reg_val[bpdc_pkg::RegPoll]      = bpdc_pkg::PollReset;
    reg_val[bpdc_pkg::RegLongPress] = bpdc_pkg::LongPressReset;
    press_phase      = bpdc_pkg::PhIdle;
    ticks_since_edge = '0;
    ticks_since_poll = '0;
    latched_button   = '0;
    last_levels      = '0;
    mismatch_count   = 0;
    words_sent       = 0;
    reports_seen     = 0;
    reg_writes       = 0;
    burst_left       = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_press_edges();
    test_register_extremes();
    test_random_traffic();

    // Wait out the pipeline, then count anything still owed as a failure.
    finish_phase();
    if (expected_reports.size() != 0)
      flag_mismatch("reports never delivered", 0, expected_reports.size());

    $display("Sent %0d level words and checked %0d press reports over %0d register writes,",
             words_sent, reports_seen, reg_writes);
    $display("spanning reset values, edge cases, register extremes and random settings.");
    if (mismatch_count == 0) begin
      $display("button_press_duration_classifier_top test passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("button_press_duration_classifier_top test failed");
    end
    $finish;
  end

endmodule : tb_button_press_duration_classifier_top

// File: button_press_duration_classifier_top.f
hw/rtl/bpdc_pkg.sv
hw/rtl/bpdc_if.sv
hw/rtl/button_press_duration_classifier_top.sv
bench/tb_button_press_duration_classifier_top.sv
